// ===== rtl/hsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hsm_pkg;

  localparam int TEMP_BITS = 16;
  // rate numerator: temperature difference times 16000
  localparam int NUM_W = TEMP_BITS + 15;
  localparam int DIV_W = (NUM_W > 32) ? NUM_W : 32;
  localparam int DEN_W = 17;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [2:0] CFG_BAD_READ_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_MAX_TEMPERATURE = 3'd1;
  localparam logic [2:0] CFG_MAX_RISE_RATE   = 3'd2;
  localparam logic [2:0] CFG_RUNAWAY_HOLD_MS = 3'd3;
  localparam logic [2:0] CFG_DUTY_OFF_LEVEL  = 3'd4;
  localparam logic [2:0] CFG_OFF_RISE_LIMIT  = 3'd5;

  localparam logic [2:0] FAULT_NONE     = 3'd0;
  localparam logic [2:0] FAULT_SENSOR   = 3'd1;
  localparam logic [2:0] FAULT_OVERTEMP = 3'd2;
  localparam logic [2:0] FAULT_RUNAWAY  = 3'd3;
  localparam logic [2:0] FAULT_OFF_RISE = 3'd4;

  localparam logic [7:0]  RST_BAD_READ_LIMIT  = 8'd3;
  localparam logic [15:0] RST_MAX_TEMPERATURE = 16'd4160;
  localparam logic [30:0] RST_MAX_RISE_RATE   = 31'd768;
  localparam logic [31:0] RST_RUNAWAY_HOLD_MS = 32'd10000;
  localparam logic [15:0] RST_DUTY_OFF_LEVEL  = 16'd655;
  localparam logic [14:0] RST_OFF_RISE_LIMIT  = 15'd80;

  typedef struct packed {
    logic                        mode;
    logic                        sensor_valid;
    logic signed [TEMP_BITS-1:0] temperature;
    logic [15:0]                 heater_duty;
    logic [15:0]                 interval_ms;
  } hsm_in_t;

  typedef struct packed {
    logic       heater_allowed;
    logic [2:0] fault_code;
  } hsm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_DIV_COEF,
    ST_MULT,
    ST_ACCUM,
    ST_FINISH
  } hsm_state_t;

endpackage
`default_nettype wire

// ===== rtl/heater_safety_monitor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Latching heater safety monitor. Each input transfer carries one sample (or a clear
// command when mode is 1) and yields exactly one output transfer with heater_allowed and
// the latched fault code. A sample that updates the rise-rate filter runs two radix-2
// divisions of 32 steps each on one shared divider (rate and filter coefficient), then the
// multiply, accumulate and finish states. Clears, bad reads, over-temperature,
// latched samples and the first good sample after a gap skip straight to the finish state.
// in_stall stays high while a sample is in work; a finished result sits in the output
// register, so the next sample is taken even while out_stall holds the last one.
// Configuration writes are applied at once and should only be issued while the block
// is idle.
module heater_safety_monitor_core
  import hsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire hsm_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output hsm_out_t         out_data,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration registers
  logic [7:0]  bad_read_limit;
  logic [15:0] max_temperature;
  logic [30:0] max_rise_rate;
  logic [31:0] runaway_hold_ms;
  logic [15:0] duty_off_level;
  logic [14:0] off_rise_limit;

  // monitor state
  logic [2:0]                  latched_fault;
  logic [7:0]                  bad_read_count;
  logic signed [TEMP_BITS-1:0] previous_temp;
  logic                        previous_valid;
  logic signed [31:0]          filtered_rate;
  logic [31:0]                 runaway_elapsed;
  logic                        off_window_active;
  logic signed [TEMP_BITS-1:0] off_window_temp;

  // sequencer and datapath registers
  hsm_state_t         state;
  hsm_state_t         state_next;
  hsm_in_t            item;
  logic [DIV_W-1:0]   dq;
  logic [DEN_W-1:0]   drem;
  logic [DEN_W-1:0]   dden;
  logic [CNT_W-1:0]   cnt;
  logic               rate_neg;
  logic signed [31:0] inst_rate;
  logic [16:0]        coef;
  logic signed [50:0] prod;

  logic in_fire;
  logic fin_fire;
  logic div_last;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign fin_fire = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign div_last = (cnt == CNT_W'(DIV_W - 1));

  // ------------------------------------------------------------------
  // decisions at the input transfer
  // ------------------------------------------------------------------
  logic                      in_over_temp;
  logic                      use_filter;
  logic signed [TEMP_BITS:0] temp_diff;
  logic signed [NUM_W-1:0]   rate_num;
  logic [NUM_W-1:0]          rate_mag;
  logic [DEN_W-1:0]          rate_den;

  always_comb begin
    in_over_temp = (in_data.temperature > $signed(max_temperature));
    use_filter = !in_data.mode && (latched_fault == FAULT_NONE) && in_data.sensor_valid
                 && !in_over_temp && previous_valid;
    temp_diff = $signed({in_data.temperature[TEMP_BITS-1], in_data.temperature})
                - $signed({previous_temp[TEMP_BITS-1], previous_temp});
    // widen both operands so the product keeps all its bits
    rate_num = $signed(NUM_W'(temp_diff)) * $signed(NUM_W'(16000));
    rate_mag = rate_num[NUM_W-1] ? NUM_W'(-rate_num) : NUM_W'(rate_num);
    rate_den = (in_data.interval_ms == 16'd0) ? DEN_W'(1000) : DEN_W'(in_data.interval_ms);
  end

  // ------------------------------------------------------------------
  // shared restoring divider step, one quotient bit per cycle
  // ------------------------------------------------------------------
  logic [DEN_W:0]   div_shift;
  logic [DEN_W:0]   div_trial;
  logic             div_ge;
  logic [DEN_W-1:0] drem_next;
  logic [DIV_W-1:0] dq_next;

  always_comb begin
    div_shift = {drem, dq[DIV_W-1]};
    div_trial = div_shift - {1'b0, dden};
    div_ge    = !div_trial[DEN_W];
    drem_next = div_ge ? div_trial[DEN_W-1:0] : div_shift[DEN_W-1:0];
    dq_next   = {dq[DIV_W-2:0], div_ge};
  end

  // signed, saturated rate from the final quotient
  logic signed [31:0] inst_sat;

  always_comb begin
    if (!rate_neg) begin
      inst_sat = (dq_next > DIV_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff
                                                   : $signed(dq_next[31:0]);
    end else begin
      inst_sat = (dq_next > DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                     : $signed(-dq_next[31:0]);
    end
  end

  // ------------------------------------------------------------------
  // filter multiply and accumulate
  // ------------------------------------------------------------------
  logic signed [32:0] rate_diff;
  logic signed [35:0] acc_sum;
  logic signed [31:0] acc_sat;

  always_comb begin
    rate_diff = $signed({inst_rate[31], inst_rate}) - $signed({filtered_rate[31], filtered_rate});
    // arithmetic shift right by 16 floors toward minus infinity
    acc_sum = $signed({prod[50], prod[50:16]}) + $signed({{4{filtered_rate[31]}}, filtered_rate});
    if (acc_sum > 36'sh0_7fff_ffff) begin
      acc_sat = 32'sh7fff_ffff;
    end else if (acc_sum < -36'sh0_8000_0000) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  // ------------------------------------------------------------------
  // finish: fault decisions and state update for the held item
  // ------------------------------------------------------------------
  logic [2:0]                  fault_next;
  logic [7:0]                  bad_count_next;
  logic                        prev_valid_next;
  logic signed [TEMP_BITS-1:0] prev_temp_next;
  logic [31:0]                 elapsed_next;
  logic                        window_active_next;
  logic signed [TEMP_BITS-1:0] window_temp_next;
  logic                        clear_all;
  logic [32:0]                 elapsed_sum;
  logic [31:0]                 elapsed_sat;
  logic signed [TEMP_BITS:0]   window_rise;

  always_comb begin
    fault_next         = latched_fault;
    bad_count_next     = bad_read_count;
    prev_valid_next    = previous_valid;
    prev_temp_next     = previous_temp;
    elapsed_next       = runaway_elapsed;
    window_active_next = off_window_active;
    window_temp_next   = off_window_temp;
    clear_all          = item.mode;
    elapsed_sum = {1'b0, runaway_elapsed} + 33'(item.interval_ms);
    elapsed_sat = elapsed_sum[32] ? 32'hffff_ffff : elapsed_sum[31:0];
    window_rise = $signed({item.temperature[TEMP_BITS-1], item.temperature})
                  - $signed({off_window_temp[TEMP_BITS-1], off_window_temp});
    if (item.mode) begin
      fault_next = FAULT_NONE;
    end else if (latched_fault != FAULT_NONE) begin
      fault_next = latched_fault;
    end else if (!item.sensor_valid) begin
      if (bad_read_count != 8'hff) begin
        bad_count_next = bad_read_count + 8'd1;
      end
      prev_valid_next    = 1'b0;
      window_active_next = 1'b0;
      if (bad_count_next >= bad_read_limit) begin
        fault_next = FAULT_SENSOR;
      end
    end else begin
      bad_count_next = 8'd0;
      if (item.temperature > $signed(max_temperature)) begin
        fault_next = FAULT_OVERTEMP;
      end else begin
        prev_temp_next  = item.temperature;
        prev_valid_next = 1'b1;
        if (filtered_rate > $signed({1'b0, max_rise_rate})) begin
          elapsed_next = elapsed_sat;
        end else begin
          elapsed_next = 32'd0;
        end
        if ((filtered_rate > $signed({1'b0, max_rise_rate}))
            && (elapsed_sat >= runaway_hold_ms)) begin
          fault_next = FAULT_RUNAWAY;
        end else if (item.heater_duty <= duty_off_level) begin
          if (!off_window_active) begin
            window_active_next = 1'b1;
            window_temp_next   = item.temperature;
          end else if (window_rise > $signed({1'b0, off_rise_limit})) begin
            fault_next = FAULT_OFF_RISE;
          end
        end else begin
          window_active_next = 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = use_filter ? ST_DIV_RATE : ST_FINISH;
        end
      end
      ST_DIV_RATE: begin
        if (div_last) begin
          state_next = ST_DIV_COEF;
        end
      end
      ST_DIV_COEF: begin
        if (div_last) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT:   state_next = ST_ACCUM;
      ST_ACCUM:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (fin_fire) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // datapath
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item     <= in_data;
      dq       <= DIV_W'(rate_mag);
      dden     <= rate_den;
      drem     <= '0;
      cnt      <= '0;
      rate_neg <= rate_num[NUM_W-1];
    end else if ((state == ST_DIV_RATE) && div_last) begin
      // load the coefficient division dt * 65536 / (dt + 1000)
      inst_rate <= inst_sat;
      dq        <= DIV_W'({item.interval_ms, 16'h0000});
      dden      <= DEN_W'(item.interval_ms) + DEN_W'(1000);
      drem      <= '0;
      cnt       <= '0;
    end else if ((state == ST_DIV_RATE) || (state == ST_DIV_COEF)) begin
      dq   <= dq_next;
      drem <= drem_next;
      cnt  <= cnt + CNT_W'(1);
    end
    if ((state == ST_DIV_COEF) && div_last) begin
      coef <= (item.interval_ms == 16'd0) ? 17'h10000 : dq_next[16:0];
    end
    if (state == ST_MULT) begin
      prod <= rate_diff * $signed({1'b0, coef});
    end
  end

  // monitor state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_read_limit    <= RST_BAD_READ_LIMIT;
      max_temperature   <= RST_MAX_TEMPERATURE;
      max_rise_rate     <= RST_MAX_RISE_RATE;
      runaway_hold_ms   <= RST_RUNAWAY_HOLD_MS;
      duty_off_level    <= RST_DUTY_OFF_LEVEL;
      off_rise_limit    <= RST_OFF_RISE_LIMIT;
      latched_fault     <= FAULT_NONE;
      bad_read_count    <= 8'd0;
      previous_temp     <= '0;
      previous_valid    <= 1'b0;
      filtered_rate     <= 32'sd0;
      runaway_elapsed   <= 32'd0;
      off_window_active <= 1'b0;
      off_window_temp   <= '0;
      out_valid         <= 1'b0;
      out_data          <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BAD_READ_LIMIT:  bad_read_limit  <= cfg_data[7:0];
          CFG_MAX_TEMPERATURE: max_temperature <= cfg_data[15:0];
          CFG_MAX_RISE_RATE:   max_rise_rate   <= cfg_data[30:0];
          CFG_RUNAWAY_HOLD_MS: runaway_hold_ms <= cfg_data;
          CFG_DUTY_OFF_LEVEL:  duty_off_level  <= cfg_data[15:0];
          CFG_OFF_RISE_LIMIT:  off_rise_limit  <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (state == ST_ACCUM) begin
        filtered_rate <= acc_sat;
      end
      if (fin_fire) begin
        if (clear_all) begin
          latched_fault     <= FAULT_NONE;
          bad_read_count    <= 8'd0;
          previous_temp     <= '0;
          previous_valid    <= 1'b0;
          filtered_rate     <= 32'sd0;
          runaway_elapsed   <= 32'd0;
          off_window_active <= 1'b0;
          off_window_temp   <= '0;
        end else begin
          latched_fault     <= fault_next;
          bad_read_count    <= bad_count_next;
          previous_temp     <= prev_temp_next;
          previous_valid    <= prev_valid_next;
          runaway_elapsed   <= elapsed_next;
          off_window_active <= window_active_next;
          off_window_temp   <= window_temp_next;
        end
        out_valid               <= 1'b1;
        out_data.heater_allowed <= (fault_next == FAULT_NONE);
        out_data.fault_code     <= fault_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  // fault codes stay within the defined set
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.fault_code <= FAULT_OFF_RISE))
    else $error("fault code out of range");

  // heater permission agrees with the reported code
  a_allowed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.heater_allowed == (out_data.fault_code == FAULT_NONE)))
    else $error("heater_allowed disagrees with fault code");

  // a sample against a latched fault never runs the divider
  a_latched_skip: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_data.mode && (latched_fault != FAULT_NONE)) |=> (state == ST_FINISH))
    else $error("latched sample entered the filter path");

  // the filter only moves in the accumulate cycle or on a clear
  a_filter_hold: assert property (@(posedge clk) disable iff (rst)
    ((state != ST_ACCUM) && !(fin_fire && clear_all)) |=> $stable(filtered_rate))
    else $error("filtered rate changed outside accumulate");

endmodule
`default_nettype wire

// ===== tb/hsm_checker.sv =====
`timescale 1ns / 1ps
module hsm_checker
  import hsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire hsm_in_t     in_data,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire hsm_out_t    out_data,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  logic [7:0]  lim_bad;
  logic signed [15:0] lim_temp;
  logic [30:0] lim_rate;
  logic [31:0] lim_hold;
  logic [15:0] lim_duty;
  logic [14:0] lim_rise;

  logic [2:0]  fault_q;
  logic [7:0]  bad_cnt;
  logic signed [15:0] last_temp;
  logic        prev_ok;
  longint      rate_est;
  longint      run_ms;
  logic        win_on;
  logic signed [15:0] win_temp;

  hsm_out_t expected_q[$];

  assign pending = expected_q.size();

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic clear_monitor();
    fault_q = FAULT_NONE;
    bad_cnt = 8'd0;
    last_temp = '0;
    prev_ok = 1'b0;
    rate_est = 0;
    run_ms = 0;
    win_on = 1'b0;
    win_temp = '0;
  endtask

  task automatic apply_sample(hsm_in_t s);
    longint t, d, inst, a, prod, step;
    t = longint'(s.temperature);
    d = longint'(s.interval_ms);
    if (fault_q != FAULT_NONE) return;
    if (!s.sensor_valid) begin
      if (bad_cnt != 8'hff) bad_cnt++;
      prev_ok = 1'b0;
      win_on = 1'b0;
      if (bad_cnt >= lim_bad) fault_q = FAULT_SENSOR;
      return;
    end
    bad_cnt = 8'd0;
    if (t > longint'(lim_temp)) begin
      fault_q = FAULT_OVERTEMP;
      return;
    end
    if (prev_ok) begin
      inst = clamp32(((t - longint'(last_temp)) * 16000) / ((d != 0) ? d : 1000));
      a = (d != 0) ? ((d << 16) / (d + 1000)) : 65536;
      prod = (inst - rate_est) * a;
      // floor division by 2^16
      step = (prod >= 0) ? (prod >>> 16) : -((-prod + 65535) >>> 16);
      rate_est = clamp32(rate_est + step);
    end
    last_temp = s.temperature;
    prev_ok = 1'b1;
    if (rate_est > longint'(lim_rate)) begin
      run_ms += d;
      if (run_ms > 64'hffffffff) run_ms = 64'hffffffff;
      if (run_ms >= longint'(lim_hold)) begin
        fault_q = FAULT_RUNAWAY;
        return;
      end
    end else begin
      run_ms = 0;
    end
    if (s.heater_duty <= lim_duty) begin
      if (!win_on) begin
        win_on = 1'b1;
        win_temp = s.temperature;
      end else if (t - longint'(win_temp) > longint'(lim_rise)) begin
        fault_q = FAULT_OFF_RISE;
      end
    end else begin
      win_on = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    hsm_out_t want;
    if (rst) begin
      lim_bad = RST_BAD_READ_LIMIT;
      lim_temp = RST_MAX_TEMPERATURE;
      lim_rate = RST_MAX_RISE_RATE;
      lim_hold = RST_RUNAWAY_HOLD_MS;
      lim_duty = RST_DUTY_OFF_LEVEL;
      lim_rise = RST_OFF_RISE_LIMIT;
      clear_monitor();
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BAD_READ_LIMIT:  lim_bad = cfg_data[7:0];
          CFG_MAX_TEMPERATURE: lim_temp = cfg_data[15:0];
          CFG_MAX_RISE_RATE:   lim_rate = cfg_data[30:0];
          CFG_RUNAWAY_HOLD_MS: lim_hold = cfg_data;
          CFG_DUTY_OFF_LEVEL:  lim_duty = cfg_data[15:0];
          CFG_OFF_RISE_LIMIT:  lim_rise = cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.heater_allowed !== want.heater_allowed)
            report_mismatch("heater_allowed", int'(out_data.heater_allowed),
                            int'(want.heater_allowed));
          if (out_data.fault_code !== want.fault_code)
            report_mismatch("fault_code", int'(out_data.fault_code), int'(want.fault_code));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.mode) clear_monitor();
        else apply_sample(in_data);
        want.heater_allowed = (fault_q == FAULT_NONE);
        want.fault_code = fault_q;
        expected_q.push_back(want);
      end
    end
  end

endmodule

// ===== tb/tb_heater_safety_monitor_core.sv =====
`timescale 1ns / 1ps
module tb_heater_safety_monitor_core;
  import hsm_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  hsm_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  hsm_out_t    out_data;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycle_count;

  // limit on the total run length, checked by the watchdog below
  localparam int CYCLE_LIMIT = 1500000;

  heater_safety_monitor_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hsm_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog on total run length
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // receiver side stall pattern, with quiet stretches
  initial begin
    int n;
    out_stall = 0;
    @(negedge clk);
    forever begin
      n = gap_len();
      if ($urandom_range(0, 9) == 0) n = 0;
      if (n != 0) begin
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // one input transfer, with an optional idle gap ahead of it
  task automatic send_item(hsm_in_t item, bit no_gap);
    int n;
    n = no_gap ? 0 : gap_len();
    if (n != 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(bit m, bit sv, int t, int duty, int dt);
    hsm_in_t item;
    item.mode = m;
    item.sensor_valid = sv;
    item.temperature = 16'(t);
    item.heater_duty = 16'(duty);
    item.interval_ms = 16'(dt);
    send_item(item, $urandom_range(0, 3) == 0);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // idle margin after the last expected output has been taken
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    @(negedge clk);
  endtask

  // a mostly plausible heating profile with random faults mixed in
  task automatic random_phase(int count);
    int t, duty, dt, r;
    t = $urandom_range(0, 1600);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_sample(1, 1'($urandom), $urandom, $urandom, $urandom);
      end else if (r < 10) begin
        send_sample(0, 0, $urandom, $urandom, $urandom);
      end else if (r < 16) begin
        send_sample(0, 1'($urandom), $urandom, $urandom, $urandom);
      end else begin
        t = t + $signed($urandom_range(0, 40)) - 16;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        duty = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 800) : $urandom;
        dt = ($urandom_range(0, 15) == 0) ? 0 :
             ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(50, 1000);
        send_sample(0, 1, t, duty, dt);
      end
      // clear often enough that latched faults do not swallow the run
      if ($urandom_range(0, 24) == 0) send_sample(1, 1, 0, 0, 0);
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_write = 0;
    cfg_index = CFG_BAD_READ_LIMIT;
    cfg_data = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes, clears, each fault kind
    send_sample(0, 1, 100, 65535, 0);
    send_sample(0, 1, 200, 65535, 0);
    send_sample(0, 1, -32768, 65535, 65535);
    send_sample(0, 1, 32767, 0, 1);
    send_sample(1, 1, 0, 0, 0);
    send_sample(0, 0, 0, 0, 0);
    send_sample(0, 0, 0, 0, 0);
    send_sample(0, 0, 0, 0, 0);
    send_sample(0, 1, 0, 0, 0);
    send_sample(1, 0, -1, 65535, 65535);
    send_sample(0, 1, 100, 0, 100);
    send_sample(0, 1, 150, 0, 100);
    send_sample(0, 1, 300, 0, 100);
    send_sample(1, 1, 0, 0, 0);
    send_sample(0, 1, 0, 65535, 1);
    send_sample(0, 1, 4000, 65535, 1);
    send_sample(0, 1, 4000, 65535, 65535);
    send_sample(1, 1, 0, 0, 0);
    drain();

    // zero limits: first bad read and first fast rise trip
    write_reg(CFG_BAD_READ_LIMIT, 0);
    write_reg(CFG_RUNAWAY_HOLD_MS, 0);
    write_reg(CFG_MAX_RISE_RATE, 0);
    write_reg(CFG_OFF_RISE_LIMIT, 0);
    send_sample(0, 0, 0, 0, 0);
    send_sample(1, 1, 0, 0, 0);
    send_sample(0, 1, 10, 65535, 10);
    send_sample(0, 1, 11, 65535, 10);
    send_sample(1, 1, 0, 0, 0);
    random_phase(200);
    drain();

    // maximum limits
    write_reg(CFG_BAD_READ_LIMIT, 255);
    write_reg(CFG_MAX_TEMPERATURE, 32'h7fff);
    write_reg(CFG_MAX_RISE_RATE, 32'h7fffffff);
    write_reg(CFG_RUNAWAY_HOLD_MS, 32'hffffffff);
    write_reg(CFG_DUTY_OFF_LEVEL, 32'hffff);
    write_reg(CFG_OFF_RISE_LIMIT, 32'h7fff);
    random_phase(250);
    drain();

    // minimum temperature cutoff and minimum off level
    write_reg(CFG_MAX_TEMPERATURE, 32'h8000);
    write_reg(CFG_DUTY_OFF_LEVEL, 0);
    send_sample(1, 1, 0, 0, 0);
    random_phase(100);
    drain();

    // several random settings
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_BAD_READ_LIMIT, $urandom_range(0, 12));
      write_reg(CFG_MAX_TEMPERATURE, $urandom_range(1200, 6000));
      write_reg(CFG_MAX_RISE_RATE, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000));
      write_reg(CFG_RUNAWAY_HOLD_MS, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000));
      write_reg(CFG_DUTY_OFF_LEVEL, $urandom);
      write_reg(CFG_OFF_RISE_LIMIT, $urandom_range(0, 32767) >> $urandom_range(0, 10));
      send_sample(1, 1, 0, 0, 0);
      random_phase(160);
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== heater_safety_monitor_core.f =====
rtl/hsm_pkg.sv
rtl/heater_safety_monitor_core.sv
tb/hsm_checker.sv
tb/tb_heater_safety_monitor_core.sv
